// ===== src/filtered_noise_burst_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Noise burst generator assertion macros
// Clocked assertion shorthands shared by the noise burst generator RTL.
// ----------------------------------------------------------------------------
`ifndef FILTERED_NOISE_BURST_GENERATOR_MACROS_SVH
`define FILTERED_NOISE_BURST_GENERATOR_MACROS_SVH

// same-cycle implication
`define FNBG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FNBG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fnbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Noise burst generator package
// Constants, register map, microcode types and the microcode program.
// ----------------------------------------------------------------------------
package fnbg_pkg;

   localparam int CFG_COEF_BITS   = 16;
   localparam int CFG_SAMPLE_BITS = 16;
   localparam int CFG_LENGTH_BITS = 18;

   localparam int SEED_BITS      = 32;
   localparam int FILT_BITS      = 24;
   localparam int FILT_FRAC      = 22;
   localparam int NOISE_BITS     = 16;
   localparam int NOISE_LSB      = 8;
   localparam int NOISE_SHIFT    = FILT_FRAC - (NOISE_BITS - 1);
   localparam int LCG_MULT_BITS  = 21;
   localparam int MUL_A_BITS     = SEED_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SEED_BITS-1:0]     LCG_MULT = 32'd1664525;
   localparam logic [SEED_BITS-1:0]     LCG_INC  = 32'd1013904223;

   localparam int unsigned RST_SEED         = 1;
   localparam int unsigned RST_LP_COEF      = 32768;
   localparam int unsigned RST_HP_COEF      = 58982;
   localparam int unsigned RST_AMPLITUDE    = 16384;
   localparam int unsigned RST_DECAY        = 65000;
   localparam int unsigned RST_ATTACK_STEP  = 2477;
   localparam int unsigned RST_BURST_LENGTH = 11466;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NOISE_SEED,
      CSR_LOWPASS_COEF,
      CSR_HIGHPASS_COEF,
      CSR_AMPLITUDE,
      CSR_DECAY_FACTOR,
      CSR_ATTACK_STEP,
      CSR_BURST_LENGTH
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_LCG, MUL_LP, MUL_HP, MUL_P1, MUL_P2, MUL_ENV, MUL_P3
   } mul_op_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_LCG, WB_LP, WB_HP, WB_P1, WB_P2, WB_ENV, WB_OUT
   } wb_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,     // fall through
      JMP_ACCEPT,   // hold until an input transfer
      JMP_IDLE,     // go to target when no burst runs
      JMP_OUTFREE   // go to target once the output register is free
   } jmp_type;

   localparam int UPC_BITS = 4;

   localparam logic [UPC_BITS-1:0] STEP_WAIT   = 4'd0;
   localparam logic [UPC_BITS-1:0] STEP_CHECK  = 4'd1;
   localparam logic [UPC_BITS-1:0] STEP_LCG_WB = 4'd2;
   localparam logic [UPC_BITS-1:0] STEP_LP_MUL = 4'd3;
   localparam logic [UPC_BITS-1:0] STEP_LP_WB  = 4'd4;
   localparam logic [UPC_BITS-1:0] STEP_HP_MUL = 4'd5;
   localparam logic [UPC_BITS-1:0] STEP_HP_WB  = 4'd6;
   localparam logic [UPC_BITS-1:0] STEP_P1_MUL = 4'd7;
   localparam logic [UPC_BITS-1:0] STEP_P1_WB  = 4'd8;
   localparam logic [UPC_BITS-1:0] STEP_P2_MUL = 4'd9;
   localparam logic [UPC_BITS-1:0] STEP_P2_WB  = 4'd10;
   localparam logic [UPC_BITS-1:0] STEP_P3_MUL = 4'd11;
   localparam logic [UPC_BITS-1:0] STEP_OUT    = 4'd12;

   typedef struct packed {
      mul_op_type          mul;
      wb_op_type           wb;
      jmp_type             jmp;
      logic [UPC_BITS-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [UPC_BITS-1:0] pc);
      ucode_type w;
      w.mul    = MUL_NONE;
      w.wb     = WB_NONE;
      w.jmp    = JMP_NEXT;
      w.target = STEP_WAIT;
      case (pc)
         STEP_WAIT: begin
            w.jmp = JMP_ACCEPT;
         end
         STEP_CHECK: begin
            w.mul    = MUL_LCG;
            w.jmp    = JMP_IDLE;
            w.target = STEP_OUT;
         end
         STEP_LCG_WB: begin
            w.wb = WB_LCG;
         end
         STEP_LP_MUL: begin
            w.mul = MUL_LP;
         end
         STEP_LP_WB: begin
            w.wb = WB_LP;
         end
         STEP_HP_MUL: begin
            w.mul = MUL_HP;
         end
         STEP_HP_WB: begin
            w.wb = WB_HP;
         end
         STEP_P1_MUL: begin
            w.mul = MUL_P1;
         end
         STEP_P1_WB: begin
            w.wb = WB_P1;
         end
         STEP_P2_MUL: begin
            w.mul = MUL_P2;
         end
         STEP_P2_WB: begin
            w.wb  = WB_P2;
            w.mul = MUL_ENV;
         end
         STEP_P3_MUL: begin
            w.wb  = WB_ENV;
            w.mul = MUL_P3;
         end
         STEP_OUT: begin
            w.wb     = WB_OUT;
            w.jmp    = JMP_OUTFREE;
            w.target = STEP_WAIT;
         end
         default: begin
            w.jmp = JMP_NEXT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== src/filtered_noise_burst_generator.sv =====
// ----------------------------------------------------------------------------
// Filtered noise burst generator
// Percussive noise voice: LCG white noise through a one-pole lowpass and a
// one-pole highpass, scaled by amplitude, a decaying envelope and a linear
// attack ramp, saturated to SAMPLE_BITS, with a flag on the last sample of
// the burst. Every input transfer yields one output transfer. A sample of a
// running burst is computed by a microcode program that runs seven products
// (generator step, two filters, three gains, envelope decay) through one
// shared multiplier with a registered product, each product followed by a
// write-back step. While no burst runs the program skips from its check
// step to its output step, and the sample is silent. A finished result
// waits in the output register; the next input is taken meanwhile, and
// the sequencer only holds at its last step if that register is still
// full. Register writes are always taken.
// ----------------------------------------------------------------------------
`include "filtered_noise_burst_generator_macros.svh"

module filtered_noise_burst_generator
   import fnbg_pkg::*;
#(
   parameter int COEF_BITS   = CFG_COEF_BITS,
   parameter int SAMPLE_BITS = CFG_SAMPLE_BITS,
   parameter int LENGTH_BITS = CFG_LENGTH_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last_sample,
   output logic                          rsp_active,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int MB      = (COEF_BITS + 1 > LCG_MULT_BITS) ? COEF_BITS + 1 : LCG_MULT_BITS;
   localparam int AW      = MUL_A_BITS;
   localparam int PW      = AW + MB + 1;
   localparam int PPW     = FILT_BITS + 2;
   localparam int LPW     = FILT_BITS + 3;
   localparam int OUT_RSH = (FILT_FRAC >= SAMPLE_BITS - 1) ? FILT_FRAC - (SAMPLE_BITS - 1) : 0;
   localparam int OUT_LSH = (FILT_FRAC < SAMPLE_BITS - 1) ? (SAMPLE_BITS - 1) - FILT_FRAC : 0;
   localparam int OUT_SH  = COEF_BITS + OUT_RSH;

   localparam logic signed [PW-1:0] ONE_PW  = PW'(1);
   localparam logic signed [PW-1:0] HALF_C  = ONE_PW <<< (COEF_BITS - 1);
   localparam logic signed [PW-1:0] HALF_C1 = ONE_PW <<< (COEF_BITS - 2);
   localparam logic signed [PW-1:0] HALF_O  = ONE_PW <<< (OUT_SH - 1);
   localparam logic [COEF_BITS:0]   ONE_Q   = {1'b1, {COEF_BITS{1'b0}}};

   function automatic logic signed [FILT_BITS-1:0] sat_filt(input logic signed [LPW-1:0] v);
      logic sgn;
      sgn = v[LPW-1];
      if (v[LPW-1:FILT_BITS-1] == {(LPW - FILT_BITS + 1){sgn}}) begin
         return v[FILT_BITS-1:0];
      end
      return {sgn, {(FILT_BITS - 1){~sgn}}};
   endfunction

   // configuration
   logic [SEED_BITS-1:0]   seed_ff, seed_in;
   logic [COEF_BITS-1:0]   lp_coef_ff, lp_coef_in;
   logic [COEF_BITS-1:0]   hp_coef_ff, hp_coef_in;
   logic [COEF_BITS-1:0]   amp_ff, amp_in;
   logic [COEF_BITS-1:0]   decay_ff, decay_in;
   logic [COEF_BITS:0]     atk_step_ff, atk_step_in;
   logic [LENGTH_BITS-1:0] burst_len_ff, burst_len_in;

   // voice state
   logic [SEED_BITS-1:0]        lcg_ff, lcg_in;
   logic signed [FILT_BITS-1:0] lp_ff, lp_in;
   logic signed [FILT_BITS-1:0] hp_ff, hp_in;
   logic signed [FILT_BITS-1:0] prev_ff, prev_in;
   logic [COEF_BITS:0]          env_ff, env_in;
   logic [COEF_BITS:0]          att_ff, att_in;
   logic [LENGTH_BITS-1:0]      idx_ff, idx_in;
   logic                        running_ff, running_in;

   // sequencer and datapath
   logic [UPC_BITS-1:0]  upc_ff, upc_in;
   ucode_type            uc;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PPW-1:0] p_ff, p_in;
   logic signed [AW-1:0] mul_a;
   logic [MB-1:0]        mul_b;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_active_ff, rsp_active_in;

   logic req_accept;
   logic out_free;
   logic fire;

   logic signed [NOISE_BITS+NOISE_SHIFT-1:0] noise_x;
   logic signed [FILT_BITS:0]                lp_diff;
   logic signed [FILT_BITS+1:0]              hp_sum;
   logic signed [PW-1:0]                     rnd_c, rnd_c1, rnd_o;
   logic signed [LPW-1:0]                    lp_sum;
   logic signed [FILT_BITS-1:0]              lp_sat, hp_sat;
   logic signed [SAMPLE_BITS-1:0]            out_sat;
   logic [COEF_BITS+1:0]                     att_sum;
   logic [LENGTH_BITS-1:0]                   burst_len;
   logic [LENGTH_BITS:0]                     idx_inc;
   logic                                     is_last;

   assign uc         = ucode_rom(upc_ff);
   assign req_stall  = (uc.jmp != JMP_ACCEPT);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = (uc.wb == WB_OUT) && out_free;
   assign csr_ready  = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_last_sample = rsp_last_ff;
   assign rsp_active      = rsp_active_ff;

   // next step
   always_comb begin
      upc_in = upc_ff;
      unique case (uc.jmp)
         JMP_NEXT: begin
            upc_in = upc_ff + UPC_BITS'(1);
         end
         JMP_ACCEPT: begin
            if (req_accept) begin
               upc_in = upc_ff + UPC_BITS'(1);
            end
         end
         JMP_IDLE: begin
            upc_in = running_ff ? upc_ff + UPC_BITS'(1) : uc.target;
         end
         JMP_OUTFREE: begin
            if (out_free) begin
               upc_in = uc.target;
            end
         end
      endcase
   end

   // multiplier operands
   assign noise_x = {~lcg_ff[NOISE_LSB+NOISE_BITS-1], lcg_ff[NOISE_LSB+NOISE_BITS-2:NOISE_LSB],
                     {NOISE_SHIFT{1'b0}}};
   assign lp_diff = (FILT_BITS + 1)'(noise_x) - (FILT_BITS + 1)'(lp_ff);
   assign hp_sum  = (FILT_BITS + 2)'(hp_ff) + (FILT_BITS + 2)'(lp_ff) - (FILT_BITS + 2)'(prev_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (uc.mul)
         MUL_NONE: begin
            mul_a = '0;
         end
         MUL_LCG: begin
            mul_a = AW'({1'b0, lcg_ff});
            mul_b = MB'(LCG_MULT);
         end
         MUL_LP: begin
            mul_a = AW'(lp_diff);
            mul_b = MB'(lp_coef_ff);
         end
         MUL_HP: begin
            mul_a = AW'(hp_sum);
            mul_b = MB'(hp_coef_ff);
         end
         MUL_P1: begin
            mul_a = AW'(hp_ff);
            mul_b = MB'(amp_ff);
         end
         MUL_P2: begin
            mul_a = AW'(p_ff);
            mul_b = MB'(env_ff);
         end
         MUL_ENV: begin
            mul_a = AW'({1'b0, env_ff});
            mul_b = MB'(decay_ff);
         end
         MUL_P3: begin
            mul_a = AW'(p_ff);
            mul_b = MB'(att_ff);
         end
      endcase
   end

   assign prod_in = mul_a * $signed({1'b0, mul_b});

   // write-back arithmetic on the registered product
   assign rnd_c  = (prod_ff + HALF_C) >>> COEF_BITS;
   assign rnd_c1 = (prod_ff + HALF_C1) >>> (COEF_BITS - 1);
   assign rnd_o  = ((prod_ff <<< OUT_LSH) + HALF_O) >>> OUT_SH;

   assign lp_sum = LPW'(lp_ff) + LPW'($signed(rnd_c[FILT_BITS+1:0]));
   assign lp_sat = sat_filt(lp_sum);
   assign hp_sat = sat_filt($signed(rnd_c[LPW-1:0]));

   always_comb begin
      if (rnd_o[PW-1:SAMPLE_BITS-1] == {(PW - SAMPLE_BITS + 1){rnd_o[PW-1]}}) begin
         out_sat = rnd_o[SAMPLE_BITS-1:0];
      end else begin
         out_sat = {rnd_o[PW-1], {(SAMPLE_BITS - 1){~rnd_o[PW-1]}}};
      end
   end

   assign att_sum   = (COEF_BITS + 2)'(att_ff) + (COEF_BITS + 2)'(atk_step_ff);
   assign burst_len = (burst_len_ff == '0) ? LENGTH_BITS'(1) : burst_len_ff;
   assign idx_inc   = (LENGTH_BITS + 1)'(idx_ff) + (LENGTH_BITS + 1)'(1);
   assign is_last   = (idx_inc >= (LENGTH_BITS + 1)'(burst_len));

   // register writes
   always_comb begin
      seed_in      = seed_ff;
      lp_coef_in   = lp_coef_ff;
      hp_coef_in   = hp_coef_ff;
      amp_in       = amp_ff;
      decay_in     = decay_ff;
      atk_step_in  = atk_step_ff;
      burst_len_in = burst_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NOISE_SEED:    seed_in      = csr_wdata[SEED_BITS-1:0];
            CSR_LOWPASS_COEF:  lp_coef_in   = csr_wdata[COEF_BITS-1:0];
            CSR_HIGHPASS_COEF: hp_coef_in   = csr_wdata[COEF_BITS-1:0];
            CSR_AMPLITUDE:     amp_in       = csr_wdata[COEF_BITS-1:0];
            CSR_DECAY_FACTOR:  decay_in     = csr_wdata[COEF_BITS-1:0];
            CSR_ATTACK_STEP:   atk_step_in  = csr_wdata[COEF_BITS:0];
            CSR_BURST_LENGTH:  burst_len_in = csr_wdata[LENGTH_BITS-1:0];
            default: begin
               seed_in = seed_ff;
            end
         endcase
      end
   end

   // voice state
   always_comb begin
      lcg_in     = lcg_ff;
      lp_in      = lp_ff;
      hp_in      = hp_ff;
      prev_in    = prev_ff;
      env_in     = env_ff;
      att_in     = att_ff;
      idx_in     = idx_ff;
      running_in = running_ff;
      p_in       = p_ff;
      if (req_accept && req_restart) begin
         lcg_in     = (seed_ff == '0) ? SEED_BITS'(1) : seed_ff;
         lp_in      = '0;
         hp_in      = '0;
         prev_in    = '0;
         env_in     = ONE_Q;
         att_in     = '0;
         idx_in     = '0;
         running_in = 1'b1;
      end
      unique case (uc.wb)
         WB_NONE: begin
            p_in = p_ff;
         end
         WB_LCG: begin
            lcg_in = prod_ff[SEED_BITS-1:0] + LCG_INC;
         end
         WB_LP: begin
            lp_in = lp_sat;
         end
         WB_HP: begin
            hp_in   = hp_sat;
            prev_in = lp_ff;
         end
         WB_P1: begin
            p_in = rnd_c1[PPW-1:0];
         end
         WB_P2: begin
            p_in = rnd_c[PPW-1:0];
         end
         WB_ENV: begin
            env_in = prod_ff[2*COEF_BITS:COEF_BITS];
         end
         WB_OUT: begin
            if (fire && running_ff) begin
               att_in = (att_sum > (COEF_BITS + 2)'(ONE_Q)) ? ONE_Q : att_sum[COEF_BITS:0];
               if (is_last) begin
                  running_in = 1'b0;
               end else begin
                  idx_in = idx_inc[LENGTH_BITS-1:0];
               end
            end
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_active_in = rsp_active_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = running_ff ? out_sat : '0;
         rsp_last_in   = running_ff && is_last;
         rsp_active_in = running_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_BITS'(RST_SEED);
         lp_coef_ff   <= COEF_BITS'(RST_LP_COEF);
         hp_coef_ff   <= COEF_BITS'(RST_HP_COEF);
         amp_ff       <= COEF_BITS'(RST_AMPLITUDE);
         decay_ff     <= COEF_BITS'(RST_DECAY);
         atk_step_ff  <= (COEF_BITS + 1)'(RST_ATTACK_STEP);
         burst_len_ff <= LENGTH_BITS'(RST_BURST_LENGTH);
         lcg_ff       <= SEED_BITS'(1);
         lp_ff        <= '0;
         hp_ff        <= '0;
         prev_ff      <= '0;
         env_ff       <= ONE_Q;
         att_ff       <= '0;
         idx_ff       <= '0;
         running_ff   <= 1'b0;
         upc_ff       <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         lp_coef_ff   <= lp_coef_in;
         hp_coef_ff   <= hp_coef_in;
         amp_ff       <= amp_in;
         decay_ff     <= decay_in;
         atk_step_ff  <= atk_step_in;
         burst_len_ff <= burst_len_in;
         lcg_ff       <= lcg_in;
         lp_ff        <= lp_in;
         hp_ff        <= hp_in;
         prev_ff      <= prev_in;
         env_ff       <= env_in;
         att_ff       <= att_in;
         idx_ff       <= idx_in;
         running_ff   <= running_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.mul != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      p_ff          <= p_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_active_ff <= rsp_active_in;
   end

   `FNBG_ASSERT_NEXT(a_accept_starts_program, req_accept, upc_ff == STEP_CHECK, "transfer did not start program")
   `FNBG_ASSERT_NEXT(a_last_ends_burst, fire && rsp_last_in, !running_ff, "burst still running after last sample")
   `FNBG_ASSERT_NOW(a_gains_bounded, !reset, (att_ff <= ONE_Q) && (env_ff <= ONE_Q), "attack or envelope above one")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Noise burst generator testbench
// Drives restart ticks through the sample handshake and register writes
// through the CSR port, predicts every sample with its own copy of the
// voice (LCG noise, lowpass, highpass, gain, envelope, attack ramp, burst
// counter) and compares each output transfer in order. A short directed
// table comes first, then random bursts under three idling profiles, with
// the registers retuned after each group of items, once the voice is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import fnbg_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PLAN_ROWS = 30;
   localparam int ITEMS_PER_TUNING = 83;
   localparam logic [31:0] GEN_MULT = 32'd1664525;
   localparam logic [31:0] GEN_INC = 32'd1013904223;
   localparam csr_index_type CSR_UNMAPPED = csr_index_type'(3'd7);

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
      logic               active;
   } voice_out_t;

   typedef struct packed {
      logic               cfg;
      csr_index_type      idx;
      logic [31:0]        data;
      logic               item;
      logic               restart;
      logic               fixed;
      logic signed [15:0] sample;
      logic               last;
      logic               active;
   } plan_row_t;

   // cfg idx data item restart fixed sample last active
   localparam plan_row_t PLAN [PLAN_ROWS] = '{
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_BURST_LENGTH,  32'd1,        1'b1, 1'b1, 1'b1, 16'sd0, 1'b1, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_BURST_LENGTH,  32'd0,        1'b1, 1'b1, 1'b1, 16'sd0, 1'b1, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_BURST_LENGTH,  32'd3,        1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_ATTACK_STEP,   32'd0,        1'b1, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b1, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_NOISE_SEED,    32'd0,        1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_LOWPASS_COEF,  32'd65535,    1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_HIGHPASS_COEF, 32'd65535,    1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_AMPLITUDE,     32'd65535,    1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_DECAY_FACTOR,  32'd65535,    1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_ATTACK_STEP,   32'd65536,    1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_BURST_LENGTH,  32'd262143,   1'b1, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_NOISE_SEED,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b1, CSR_ATTACK_STEP,   32'd131071,   1'b1, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b1},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
      '{1'b0, CSR_NOISE_SEED,    32'd0,        1'b1, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic rsp_last_sample;
   logic rsp_active;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_NOISE_SEED;
   logic [31:0] csr_wdata = 32'd0;

   // voice registers
   logic [31:0] seed_cfg;
   logic [15:0] lp_cfg, hp_cfg, gain_cfg, decay_cfg;
   logic [16:0] ramp_step_cfg;
   logic [17:0] length_cfg;

   // voice state
   logic [31:0] gen_state;
   logic signed [23:0] lp_acc, hp_acc, hp_last_in;
   logic [16:0] env_gain, ramp;
   logic [17:0] pos;
   logic in_burst;

   voice_out_t pending_samples[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;

   filtered_noise_burst_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_last_sample (rsp_last_sample),
      .rsp_active      (rsp_active),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic void voice_reset();
      seed_cfg = 32'd1;
      lp_cfg = 16'd32768;
      hp_cfg = 16'd58982;
      gain_cfg = 16'd16384;
      decay_cfg = 16'd65000;
      ramp_step_cfg = 17'd2477;
      length_cfg = 18'd11466;
      gen_state = 32'd1;
      lp_acc = '0;
      hp_acc = '0;
      hp_last_in = '0;
      env_gain = 17'd65536;
      ramp = '0;
      pos = '0;
      in_burst = 1'b0;
   endfunction

   function automatic void voice_config(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_NOISE_SEED:    seed_cfg = data;
         CSR_LOWPASS_COEF:  lp_cfg = data[15:0];
         CSR_HIGHPASS_COEF: hp_cfg = data[15:0];
         CSR_AMPLITUDE:     gain_cfg = data[15:0];
         CSR_DECAY_FACTOR:  decay_cfg = data[15:0];
         CSR_ATTACK_STEP:   ramp_step_cfg = data[16:0];
         CSR_BURST_LENGTH:  length_cfg = data[17:0];
         default: ;
      endcase
   endfunction

   function automatic voice_out_t voice_step(logic restart_bit);
      longint noise, x, t, p;
      int unsigned ramp_next, pos_next, span;
      voice_out_t r;
      r = '0;
      if (restart_bit) begin
         gen_state = (seed_cfg == 32'd0) ? 32'd1 : seed_cfg;
         lp_acc = '0;
         hp_acc = '0;
         hp_last_in = '0;
         env_gain = 17'd65536;
         ramp = '0;
         pos = '0;
         in_burst = 1'b1;
      end
      if (!in_burst)
         return r;

      gen_state = gen_state * GEN_MULT + GEN_INC;
      noise = gen_state[23:8];
      x = (noise - 32768) * 128;

      t = round_shift(longint'(lp_cfg) * (x - lp_acc), 16);
      lp_acc = clamp(lp_acc + t, 24);

      t = hp_acc + lp_acc - hp_last_in;
      hp_last_in = lp_acc;
      hp_acc = clamp(round_shift(longint'(hp_cfg) * t, 16), 24);

      p = round_shift(hp_acc * longint'(gain_cfg), 15);
      p = round_shift(p * longint'(env_gain), 16);
      p = round_shift(p * longint'(ramp), 23);
      p = clamp(p, 16);

      env_gain = (longint'(env_gain) * longint'(decay_cfg)) >>> 16;
      ramp_next = ramp + ramp_step_cfg;
      ramp = (ramp_next > 32'd65536) ? 17'd65536 : ramp_next[16:0];

      span = (length_cfg == '0) ? 1 : length_cfg;
      pos_next = pos + 1;
      r.last = (pos_next >= span);
      if (r.last)
         in_burst = 1'b0;
      else
         pos = pos_next[17:0];

      r.sample = p[15:0];
      r.active = 1'b1;
      return r;
   endfunction

   task automatic flag_error(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $time, what);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_item(logic restart_bit, logic fixed, voice_out_t fixed_out);
      voice_out_t predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart_bit;
      do @(posedge clock); while (req_stall);
      predicted = voice_step(restart_bit);
      pending_samples.push_back(fixed ? fixed_out : predicted);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data, logic hold);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      voice_config(idx, data);
      if (!hold)
         csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] junk(int width);
      return ($urandom >> width) << width;
   endfunction

   task automatic retune();
      logic [31:0] v;
      case ($urandom_range(2))
         0: v = 32'd0;
         1: v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      csr_write(CSR_NOISE_SEED, v, 1'b1);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 65535;
         default: v = $urandom_range(65535);
      endcase
      csr_write(CSR_LOWPASS_COEF, v | junk(16), 1'b1);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 65535;
         default: v = $urandom_range(65535);
      endcase
      csr_write(CSR_HIGHPASS_COEF, v | junk(16), 1'b1);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 65535;
         default: v = $urandom_range(65535);
      endcase
      csr_write(CSR_AMPLITUDE, v | junk(16), 1'b1);
      csr_write(CSR_UNMAPPED, $urandom, 1'b1);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 65535;
         2: v = $urandom_range(65535);
         default: v = $urandom_range(60000, 65535);
      endcase
      csr_write(CSR_DECAY_FACTOR, v | junk(16), 1'b1);
      case ($urandom_range(5))
         0: v = 0;
         1: v = 1;
         2: v = 65536;
         3: v = 131071;
         default: v = $urandom_range(1, 8000);
      endcase
      csr_write(CSR_ATTACK_STEP, v | junk(17), 1'b1);
      case ($urandom_range(9))
         0: v = 0;
         1: v = 1;
         2: v = 262143;
         3: v = $urandom_range(100, 3000);
         default: v = $urandom_range(2, 40);
      endcase
      csr_write(CSR_BURST_LENGTH, v | junk(18), 1'b0);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_samples
      voice_out_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            flag_error($sformatf("unexpected sample %0d last %0b active %0b",
               rsp_sample, rsp_last_sample, rsp_active));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample || rsp_last_sample !== want.last ||
                rsp_active !== want.active)
               flag_error($sformatf(
                  "sample mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                  $signed(want.sample), want.last, want.active,
                  rsp_sample, rsp_last_sample, rsp_active));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      voice_out_t row_out;
      voice_out_t blank;
      blank = '0;
      voice_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 15;
      rsp_stall_pct = 72;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].cfg)
            csr_write(PLAN[i].idx, PLAN[i].data,
               i + 1 < PLAN_ROWS && !PLAN[i].item && PLAN[i + 1].cfg);
         if (PLAN[i].item) begin
            row_out.sample = PLAN[i].sample;
            row_out.last = PLAN[i].last;
            row_out.active = PLAN[i].active;
            send_item(PLAN[i].restart, PLAN[i].fixed, row_out);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 15 : ((phase == 1) ? 72 : 0);
         rsp_stall_pct = (phase == 0) ? 72 : ((phase == 1) ? 15 : 0);
         for (int tuning = 0; tuning < 4; tuning++) begin
            retune();
            // mostly restart when idle, rarely cut a running burst short
            repeat (ITEMS_PER_TUNING)
               send_item(in_burst ? ($urandom_range(99) < 3) : ($urandom_range(99) < 80),
                  1'b0, blank);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
